@@ hw/rtl/x86enc_pkg.sv @@
// ----------------------------------------------------------------------------
// x86enc_pkg
// shared types, opcode constants and byte-building helpers for the encoder
// ----------------------------------------------------------------------------
package x86enc_pkg;

	localparam int MAX_BYTES   = 10;
	localparam int BYTES_W     = MAX_BYTES * 8;
	localparam int LEN_W       = $clog2(MAX_BYTES + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [5:0] {
		CMD_ADD32_RR    = 6'd0,
		CMD_ADD32_RI8   = 6'd1,
		CMD_ADD64_RR    = 6'd2,
		CMD_ADD64_RI8   = 6'd3,
		CMD_ADD64_RI32  = 6'd4,
		CMD_SUB32_RR    = 6'd5,
		CMD_SUB64_RR    = 6'd6,
		CMD_SUB64_RI8   = 6'd7,
		CMD_SUB64_RI32  = 6'd8,
		CMD_IMUL32_RR   = 6'd9,
		CMD_IMUL64_RR   = 6'd10,
		CMD_IDIV32      = 6'd11,
		CMD_IDIV64      = 6'd12,
		CMD_MOV8_RR     = 6'd13,
		CMD_MOV16_RR    = 6'd14,
		CMD_MOV32_RI32  = 6'd15,
		CMD_MOV32_RR    = 6'd16,
		CMD_MOV64_RR    = 6'd17,
		CMD_MOV64_RI64  = 6'd18,
		CMD_MOV8_SI     = 6'd19,
		CMD_MOV8_SR     = 6'd20,
		CMD_MOV16_SI    = 6'd21,
		CMD_MOV16_SR    = 6'd22,
		CMD_MOV32_SI    = 6'd23,
		CMD_MOV32_RS    = 6'd24,
		CMD_MOV32_SR    = 6'd25,
		CMD_MOV64_SR    = 6'd26,
		CMD_MOV64_RS    = 6'd27,
		CMD_MOVZX_RS8   = 6'd28,
		CMD_MOVZX_RS16  = 6'd29,
		CMD_MOVSX_RS8   = 6'd30,
		CMD_MOVSX_RS16  = 6'd31,
		CMD_LEA64_RIP   = 6'd32,
		CMD_XOR32_RR    = 6'd33,
		CMD_XOR64_RR    = 6'd34,
		CMD_CMP32_EAXI8 = 6'd35,
		CMD_RET         = 6'd36,
		CMD_CALL_REL32  = 6'd37
	} cmd_t;

	localparam logic [1:0] MOD_INDIR = 2'd0;
	localparam logic [1:0] MOD_DISP8 = 2'd1;
	localparam logic [1:0] MOD_REG   = 2'd3;
	localparam logic [2:0] RM_RSP    = 3'd4;
	localparam logic [2:0] RM_RIP    = 3'd5;

	// opcode extensions in the modrm reg field
	localparam logic [2:0] OPX_ADD  = 3'd0;
	localparam logic [2:0] OPX_SUB  = 3'd5;
	localparam logic [2:0] OPX_IDIV = 3'd7;
	localparam logic [2:0] OPX_CMP  = 3'd7;
	localparam logic [2:0] REG_RAX  = 3'd0;

	localparam logic [7:0] REX_W_BYTE  = 8'h48;
	localparam logic [7:0] REX_R_BYTE  = 8'h44;
	localparam logic [7:0] REX_WR_BYTE = 8'h4c;
	localparam logic [7:0] OPSZ_BYTE   = 8'h66;
	localparam logic [7:0] SIB_RSP     = 8'h24;
	localparam logic [7:0] ESC_0F      = 8'h0f;

	// opcode bytes
	localparam logic [7:0] OP_ADD_RM   = 8'h03;
	localparam logic [7:0] OP_GRP1_IB  = 8'h83;
	localparam logic [7:0] OP_GRP1_ID  = 8'h81;
	localparam logic [7:0] OP_SUB_RM   = 8'h2b;
	localparam logic [7:0] OP_IMUL_RM  = 8'haf;
	localparam logic [7:0] OP_GRP3     = 8'hf7;
	localparam logic [7:0] OP_MOV8_MR  = 8'h88;
	localparam logic [7:0] OP_MOV_MR   = 8'h89;
	localparam logic [7:0] OP_MOV_RM   = 8'h8b;
	localparam logic [7:0] OP_MOV_RI   = 8'hb8;
	localparam logic [7:0] OP_MOV8_MI  = 8'hc6;
	localparam logic [7:0] OP_MOV_MI   = 8'hc7;
	localparam logic [7:0] OP_MOVZX8   = 8'hb6;
	localparam logic [7:0] OP_MOVZX16  = 8'hb7;
	localparam logic [7:0] OP_MOVSX8   = 8'hbe;
	localparam logic [7:0] OP_MOVSX16  = 8'hbf;
	localparam logic [7:0] OP_LEA      = 8'h8d;
	localparam logic [7:0] OP_XOR_RM   = 8'h33;
	localparam logic [7:0] OP_RET      = 8'hc3;
	localparam logic [7:0] OP_CALL_REL = 8'he8;

	// one encoded instruction, first byte in the low bits
	typedef struct packed {
		logic [BYTES_W-1:0] bytes;
		logic [LEN_W-1:0]   len;
	} instr_t;

	function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] reg_f,
			input logic [2:0] rm);
		modrm = {md, reg_f, rm};
	endfunction

	// modrm, sib and disp8 for rsp-relative addressing
	function automatic logic [23:0] stack_addr(input logic [2:0] reg_f,
			input logic [7:0] disp8);
		stack_addr = {disp8, SIB_RSP, modrm(MOD_DISP8, reg_f, RM_RSP)};
	endfunction

endpackage

@@ hw/rtl/x86enc_front.sv @@
// ----------------------------------------------------------------------------
// x86enc_front
// accepts requests, builds the byte sequence and length, drops unused codes
// ----------------------------------------------------------------------------
module x86enc_front import x86enc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [5:0]   cmd,
	input  logic [2:0]   dest_reg,
	input  logic [3:0]   src_reg,
	input  logic [63:0]  imm_value,
	input  logic [31:0]  displacement,
	output logic         push,
	input  logic         push_ready,
	output instr_t       push_data
);

	logic               valid_s1;
	instr_t             instr_s1;
	logic [BYTES_W-1:0] seq;
	logic [LEN_W-1:0]   len;
	logic [2:0]         d;
	logic [2:0]         s;
	logic [7:0]         d8;
	logic               accept;

	assign d  = dest_reg;
	assign s  = src_reg[2:0];
	assign d8 = displacement[7:0];

	always_comb begin
		seq = '0;
		len = '0;
		case (cmd)
			CMD_ADD32_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_ADD_RM}); len = LEN_W'(2);
			end
			CMD_ADD32_RI8: begin
				seq = BYTES_W'({imm_value[7:0], modrm(MOD_REG, OPX_ADD, d), OP_GRP1_IB});
				len = LEN_W'(3);
			end
			CMD_ADD64_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_ADD_RM, REX_W_BYTE}); len = LEN_W'(3);
			end
			CMD_ADD64_RI8: begin
				seq = BYTES_W'({imm_value[7:0], modrm(MOD_REG, OPX_ADD, d), OP_GRP1_IB,
					REX_W_BYTE});
				len = LEN_W'(4);
			end
			CMD_ADD64_RI32: begin
				seq = BYTES_W'({imm_value[31:0], modrm(MOD_REG, OPX_ADD, d), OP_GRP1_ID,
					REX_W_BYTE});
				len = LEN_W'(7);
			end
			CMD_SUB32_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_SUB_RM}); len = LEN_W'(2);
			end
			CMD_SUB64_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_SUB_RM, REX_W_BYTE}); len = LEN_W'(3);
			end
			CMD_SUB64_RI8: begin
				seq = BYTES_W'({imm_value[7:0], modrm(MOD_REG, OPX_SUB, d), OP_GRP1_IB,
					REX_W_BYTE});
				len = LEN_W'(4);
			end
			CMD_SUB64_RI32: begin
				seq = BYTES_W'({imm_value[31:0], modrm(MOD_REG, OPX_SUB, d), OP_GRP1_ID,
					REX_W_BYTE});
				len = LEN_W'(7);
			end
			CMD_IMUL32_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, d, s), OP_IMUL_RM, ESC_0F}); len = LEN_W'(3);
			end
			CMD_IMUL64_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, d, s), OP_IMUL_RM, ESC_0F, REX_W_BYTE});
				len = LEN_W'(4);
			end
			CMD_IDIV32: begin
				seq = BYTES_W'({modrm(MOD_REG, OPX_IDIV, d), OP_GRP3}); len = LEN_W'(2);
			end
			CMD_IDIV64: begin
				seq = BYTES_W'({modrm(MOD_REG, OPX_IDIV, d), OP_GRP3, REX_W_BYTE});
				len = LEN_W'(3);
			end
			CMD_MOV8_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_MOV8_MR}); len = LEN_W'(2);
			end
			CMD_MOV16_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_MOV_MR, OPSZ_BYTE}); len = LEN_W'(3);
			end
			CMD_MOV32_RI32: begin
				seq = BYTES_W'({imm_value[31:0], OP_MOV_RI[7:3], d}); len = LEN_W'(5);
			end
			CMD_MOV32_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_MOV_MR}); len = LEN_W'(2);
			end
			CMD_MOV64_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_MOV_MR, REX_W_BYTE}); len = LEN_W'(3);
			end
			CMD_MOV64_RI64: begin
				seq = BYTES_W'({imm_value, OP_MOV_RI[7:3], d, REX_W_BYTE}); len = LEN_W'(10);
			end
			CMD_MOV8_SI: begin
				seq = BYTES_W'({imm_value[7:0], stack_addr(OPX_ADD, d8), OP_MOV8_MI});
				len = LEN_W'(5);
			end
			CMD_MOV8_SR: begin
				if (src_reg[3]) begin
					seq = BYTES_W'({stack_addr(s, d8), OP_MOV8_MR, REX_R_BYTE}); len = LEN_W'(5);
				end else begin
					seq = BYTES_W'({stack_addr(s, d8), OP_MOV8_MR}); len = LEN_W'(4);
				end
			end
			CMD_MOV16_SI: begin
				seq = BYTES_W'({imm_value[15:0], stack_addr(OPX_ADD, d8), OP_MOV_MI, OPSZ_BYTE});
				len = LEN_W'(7);
			end
			CMD_MOV16_SR: begin
				if (src_reg[3]) begin
					seq = BYTES_W'({stack_addr(s, d8), OP_MOV_MR, REX_R_BYTE, OPSZ_BYTE});
					len = LEN_W'(6);
				end else begin
					seq = BYTES_W'({stack_addr(s, d8), OP_MOV_MR, OPSZ_BYTE}); len = LEN_W'(5);
				end
			end
			CMD_MOV32_SI: begin
				seq = BYTES_W'({imm_value[31:0], stack_addr(OPX_ADD, d8), OP_MOV_MI});
				len = LEN_W'(8);
			end
			CMD_MOV32_RS: begin
				seq = BYTES_W'({stack_addr(d, d8), OP_MOV_RM}); len = LEN_W'(4);
			end
			CMD_MOV32_SR: begin
				if (src_reg[3]) begin
					seq = BYTES_W'({stack_addr(s, d8), OP_MOV_MR, REX_R_BYTE}); len = LEN_W'(5);
				end else begin
					seq = BYTES_W'({stack_addr(s, d8), OP_MOV_MR}); len = LEN_W'(4);
				end
			end
			CMD_MOV64_SR: begin
				seq = BYTES_W'({stack_addr(s, d8), OP_MOV_MR,
					src_reg[3] ? REX_WR_BYTE : REX_W_BYTE});
				len = LEN_W'(5);
			end
			CMD_MOV64_RS: begin
				seq = BYTES_W'({stack_addr(d, d8), OP_MOV_RM, REX_W_BYTE}); len = LEN_W'(5);
			end
			CMD_MOVZX_RS8: begin
				seq = BYTES_W'({stack_addr(d, d8), OP_MOVZX8, ESC_0F}); len = LEN_W'(5);
			end
			CMD_MOVZX_RS16: begin
				seq = BYTES_W'({stack_addr(d, d8), OP_MOVZX16, ESC_0F}); len = LEN_W'(5);
			end
			CMD_MOVSX_RS8: begin
				seq = BYTES_W'({stack_addr(d, d8), OP_MOVSX8, ESC_0F}); len = LEN_W'(5);
			end
			CMD_MOVSX_RS16: begin
				seq = BYTES_W'({stack_addr(d, d8), OP_MOVSX16, ESC_0F}); len = LEN_W'(5);
			end
			CMD_LEA64_RIP: begin
				seq = BYTES_W'({displacement, modrm(MOD_INDIR, d, RM_RIP), OP_LEA, REX_W_BYTE});
				len = LEN_W'(7);
			end
			CMD_XOR32_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_XOR_RM}); len = LEN_W'(2);
			end
			CMD_XOR64_RR: begin
				seq = BYTES_W'({modrm(MOD_REG, s, d), OP_XOR_RM, REX_W_BYTE}); len = LEN_W'(3);
			end
			CMD_CMP32_EAXI8: begin
				seq = BYTES_W'({imm_value[7:0], modrm(MOD_REG, OPX_CMP, REG_RAX), OP_GRP1_IB});
				len = LEN_W'(3);
			end
			CMD_RET: begin
				seq = BYTES_W'(OP_RET); len = LEN_W'(1);
			end
			CMD_CALL_REL32: begin
				seq = BYTES_W'({32'h0, OP_CALL_REL}); len = LEN_W'(5);
			end
			default: begin
				seq = '0; len = '0;
			end
		endcase
	end

	// stage register frees up when the queue takes its item
	assign in_ready  = !valid_s1 || push_ready;
	assign accept    = in_valid && in_ready;
	assign push      = valid_s1;
	assign push_data = instr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			// unused codes produce no bytes and are dropped here
			valid_s1 <= (len != '0);
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1.bytes <= seq;
			instr_s1.len   <= len;
		end
	end

endmodule

@@ hw/rtl/x86enc_queue.sv @@
// ----------------------------------------------------------------------------
// x86enc_queue
// small fifo of encoded instructions between front and back
// ----------------------------------------------------------------------------
module x86enc_queue import x86enc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   push_ready,
	input  instr_t push_data,
	output logic   pop_valid,
	input  logic   pop,
	output instr_t pop_data
);

	instr_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/x86enc_back.sv @@
// ----------------------------------------------------------------------------
// x86enc_back
// shifts out one code byte per cycle while out_ready allows, with running offset and last flag
// ----------------------------------------------------------------------------
module x86enc_back import x86enc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop,
	input  instr_t       pop_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   code_byte,
	output logic [31:0]  byte_offset,
	output logic         last
);

	logic               cur_valid_q;
	logic [BYTES_W-1:0] cur_bytes_q;
	logic [LEN_W-1:0]   rem_q;
	logic [31:0]        count_q;
	logic               out_valid_q;
	logic [7:0]         code_byte_q;
	logic [31:0]        byte_offset_q;
	logic               last_q;
	logic               advance;
	logic               emit;
	logic               cur_last;

	assign advance  = !out_valid_q || out_ready;
	assign emit     = advance && cur_valid_q;
	assign cur_last = (rem_q == LEN_W'(1));
	// next instruction loads as the current one sends its final byte
	assign pop      = pop_valid && (!cur_valid_q || (emit && cur_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				rem_q       <= pop_data.len;
			end else if (emit) begin
				cur_valid_q <= !cur_last;
				rem_q       <= rem_q - 1'b1;
			end
			if (emit) begin
				count_q <= count_q + 32'd1;
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q <= pop_data.bytes;
		end else if (emit) begin
			cur_bytes_q <= cur_bytes_q >> 8;
		end
		if (emit) begin
			code_byte_q   <= cur_bytes_q[7:0];
			byte_offset_q <= count_q;
			last_q        <= cur_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_byte   = code_byte_q;
	assign byte_offset = byte_offset_q;
	assign last        = last_q;

endmodule

@@ hw/rtl/x86_64_instruction_byte_encoder.sv @@
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder
// turns instruction requests into a stream of x86-64 machine code bytes
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one request per item: cmd picks
//   one of 38 instruction forms, with dest_reg, src_reg, imm_value and
//   displacement as operands. unused cmd codes are taken and emit nothing
//   output channel (out_valid/out_ready) gives one code byte per item with
//   its running byte_offset; last marks the final byte of an instruction
//   path of a request: front stage register, queue, byte shifter, then output register
//   throughput: one byte per cycle while out_ready holds, so an instruction
//   of n bytes (1 to 10) holds the byte shifter in the back end until all n
//   have left; requests keep flowing while earlier bytes are still leaving
//   a two-entry queue sits between the decoder and the byte shifter, so a
//   stalled receiver fills the queue first and only then drops in_ready
//   reset clears the running byte count to zero and empties every stage
// ----------------------------------------------------------------------------
module x86_64_instruction_byte_encoder import x86enc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [5:0]   cmd,
	input  logic [2:0]   dest_reg,
	input  logic [3:0]   src_reg,
	input  logic [63:0]  imm_value,
	input  logic [31:0]  displacement,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   code_byte,
	output logic [31:0]  byte_offset,
	output logic         last
);

	// front to queue
	logic   push;
	logic   push_ready;
	instr_t push_data;

	// queue to back
	logic   pop_valid;
	logic   pop;
	instr_t pop_data;

	// decode: builds prefix, opcode, modrm, sib, disp and immediate bytes
	x86enc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.dest_reg     (dest_reg),
		.src_reg      (src_reg),
		.imm_value    (imm_value),
		.displacement (displacement),
		.push         (push),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// decouples decode from byte emission
	x86enc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	// serializer: one byte per cycle into the output register while out_ready allows
	x86enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop         (pop),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_byte   (code_byte),
		.byte_offset (byte_offset),
		.last        (last)
	);

endmodule
